### rtl/core/swd_pkg.sv
// Package for the touch swipe direction classifier.
// Holds event codes, direction codes, a reset constant and shared types.
// No dependencies.
package swd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int EVT_BITS       = 16;
    localparam int TRAVEL_BITS    = 17;
    localparam int DIR_BITS       = 3;

    localparam logic [EVT_BITS-1:0] EVT_KEY    = 16'd1;
    localparam logic [EVT_BITS-1:0] EVT_ABS    = 16'd3;
    localparam logic [EVT_BITS-1:0] CODE_X     = 16'd0;
    localparam logic [EVT_BITS-1:0] CODE_Y     = 16'd1;
    localparam logic [EVT_BITS-1:0] CODE_TOUCH = 16'd330;

    localparam logic [EVT_BITS-1:0] MIN_TRAVEL_RESET = 16'd30;

    typedef enum logic [DIR_BITS-1:0] {
        DIR_NONE  = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DOWN  = 3'd4
    } t_dir;

    typedef struct packed {
        logic is_x;
        logic is_y;
        logic is_release;
    } t_evt_kind;

endpackage

### rtl/core/swd_stroke.sv
// Stroke tracker: first and latest X and Y coordinates and seen flags.
// Gives the travel on each axis; clears itself on a release.
// Depends on swd_pkg.
module swd_stroke
    import swd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  t_evt_kind                    i_kind,
    input  logic signed [EVT_BITS-1:0]   i_value,
    output logic signed [COORD_BITS:0]   o_dx,
    output logic signed [COORD_BITS:0]   o_dy
);

    logic signed [COORD_BITS-1:0] r_first_x;
    logic signed [COORD_BITS-1:0] r_first_y;
    logic signed [COORD_BITS-1:0] r_latest_x;
    logic signed [COORD_BITS-1:0] r_latest_y;
    logic                         r_x_seen;
    logic                         r_y_seen;
    logic signed [31:0]           value_ext;
    logic signed [COORD_BITS-1:0] coord;

    assign value_ext = 32'(i_value);
    assign coord     = value_ext[COORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_latest_x <= '0;
            r_latest_y <= '0;
            r_x_seen   <= 1'b0;
            r_y_seen   <= 1'b0;
        end else if (i_fire) begin
            if (i_kind.is_release) begin
                r_first_x  <= '0;
                r_first_y  <= '0;
                r_latest_x <= '0;
                r_latest_y <= '0;
                r_x_seen   <= 1'b0;
                r_y_seen   <= 1'b0;
            end else if (i_kind.is_x) begin
                if (!r_x_seen) begin
                    r_first_x <= coord;
                end
                r_latest_x <= coord;
                r_x_seen   <= 1'b1;
            end else if (i_kind.is_y) begin
                if (!r_y_seen) begin
                    r_first_y <= coord;
                end
                r_latest_y <= coord;
                r_y_seen   <= 1'b1;
            end
        end
    end

    assign o_dx = r_x_seen ? ((COORD_BITS+1)'(r_latest_x) - (COORD_BITS+1)'(r_first_x)) : '0;
    assign o_dy = r_y_seen ? ((COORD_BITS+1)'(r_latest_y) - (COORD_BITS+1)'(r_first_y)) : '0;

endmodule

### rtl/core/swd_classify.sv
// Direction decision from the travel on both axes and the threshold.
// Also forms the truncated travel fields of the result.
// Depends on swd_pkg.
module swd_classify
    import swd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS:0]    i_dx,
    input  logic signed [COORD_BITS:0]    i_dy,
    input  logic        [EVT_BITS-1:0]    i_min_travel,
    output t_dir                          o_dir,
    output logic signed [TRAVEL_BITS-1:0] o_travel_x,
    output logic signed [TRAVEL_BITS-1:0] o_travel_y
);

    localparam int CW = (COORD_BITS + 3 > EVT_BITS + 2) ? COORD_BITS + 3 : EVT_BITS + 2;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] th;
    logic                 x_dom;
    logic                 y_dom;

    assign dx    = CW'(i_dx);
    assign dy    = CW'(i_dy);
    assign ax    = dx[CW-1] ? -dx : dx;
    assign ay    = dy[CW-1] ? -dy : dy;
    assign th    = signed'(CW'(i_min_travel));
    assign x_dom = ax > (ay <<< 1);
    assign y_dom = ay > (ax <<< 1);

    always_comb begin
        if (dx > th && x_dom) begin
            o_dir = DIR_RIGHT;
        end else if (dx < -th && x_dom) begin
            o_dir = DIR_LEFT;
        end else if (dy > th && y_dom) begin
            o_dir = DIR_DOWN;
        end else if (dy < -th && y_dom) begin
            o_dir = DIR_UP;
        end else begin
            o_dir = DIR_NONE;
        end
    end

    assign o_travel_x = dx[TRAVEL_BITS-1:0];
    assign o_travel_y = dy[TRAVEL_BITS-1:0];

endmodule

### rtl/core/touch_swipe_direction_classifier.sv
// Top level of the touch swipe direction classifier.
// Instantiates swd_stroke and swd_classify; depends on swd_pkg.
//
// Channel   Direction  Handshake                  Payload
// event     in         i_in_valid / o_in_ready    i_event_type, i_event_code, i_event_value
// result    out        o_out_valid / i_out_ready  o_direction, o_travel_x, o_travel_y
// config    in         i_cfg_we                   i_cfg_data (min_travel)
//
// One event is taken per cycle unless a release is held back by a stalled result register;
// a release event passes through the input register and then the result register.
// A release waits in the input register while the result register is full and stalled.
// Reset clears the stroke, both valid flags and sets min_travel to 30.
module touch_swipe_direction_classifier
    import swd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [EVT_BITS-1:0]           i_event_type,
    input  logic [EVT_BITS-1:0]           i_event_code,
    input  logic signed [EVT_BITS-1:0]    i_event_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [DIR_BITS-1:0]           o_direction,
    output logic signed [TRAVEL_BITS-1:0] o_travel_x,
    output logic signed [TRAVEL_BITS-1:0] o_travel_y,
    input  logic                          i_cfg_we,
    input  logic [EVT_BITS-1:0]           i_cfg_data
);

    logic                          r_in_valid;
    logic                          n_in_valid;
    logic [EVT_BITS-1:0]           r_type;
    logic [EVT_BITS-1:0]           r_code;
    logic signed [EVT_BITS-1:0]    r_value;
    logic [EVT_BITS-1:0]           r_min_travel;
    logic                          r_out_valid;
    logic                          n_out_valid;
    t_dir                          r_dir;
    logic signed [TRAVEL_BITS-1:0] r_travel_x;
    logic signed [TRAVEL_BITS-1:0] r_travel_y;

    t_evt_kind                     kind;
    logic                          out_free;
    logic                          fire;
    logic signed [COORD_BITS:0]    dx;
    logic signed [COORD_BITS:0]    dy;
    t_dir                          dir;
    logic signed [TRAVEL_BITS-1:0] travel_x;
    logic signed [TRAVEL_BITS-1:0] travel_y;

    assign kind.is_x       = (r_type == EVT_ABS) && (r_code == CODE_X);
    assign kind.is_y       = (r_type == EVT_ABS) && (r_code == CODE_Y);
    assign kind.is_release = (r_type == EVT_KEY) && (r_code == CODE_TOUCH) && (r_value == '0);

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && (!kind.is_release || out_free);
    assign o_in_ready = !r_in_valid || fire;

    assign n_in_valid  = i_in_valid || (r_in_valid && !fire);
    assign n_out_valid = (fire && kind.is_release) || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_min_travel <= MIN_TRAVEL_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= n_in_valid;
            end
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_min_travel <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_type  <= i_event_type;
            r_code  <= i_event_code;
            r_value <= i_event_value;
        end
        if (fire && kind.is_release) begin
            r_dir      <= dir;
            r_travel_x <= travel_x;
            r_travel_y <= travel_y;
        end
    end

    swd_stroke #(
        .COORD_BITS (COORD_BITS)
    ) u_stroke (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_kind  (kind),
        .i_value (r_value),
        .o_dx    (dx),
        .o_dy    (dy)
    );

    swd_classify #(
        .COORD_BITS (COORD_BITS)
    ) u_classify (
        .i_dx         (dx),
        .i_dy         (dy),
        .i_min_travel (r_min_travel),
        .o_dir        (dir),
        .o_travel_x   (travel_x),
        .o_travel_y   (travel_y)
    );

    assign o_out_valid = r_out_valid;
    assign o_direction = r_dir;
    assign o_travel_x  = r_travel_x;
    assign o_travel_y  = r_travel_y;

endmodule

### tb/tb_touch_swipe_direction_classifier.sv
// Self-checking testbench for the touch swipe direction classifier.
// Drives directed and random touch event streams with random idling on both sides and
// compares every result with a built-in stroke tracker or a pinned expected value; depends on swd_pkg and the RTL.
`timescale 1ns / 100ps

module tb_touch_swipe_direction_classifier;
    import swd_pkg::*;

    localparam logic [EVT_BITS-1:0] EVT_SYN = 16'd0;

    typedef struct packed {
        t_dir                          dir;
        logic signed [TRAVEL_BITS-1:0] tx;
        logic signed [TRAVEL_BITS-1:0] ty;
    } t_swipe;

    typedef struct {
        logic [EVT_BITS-1:0]        etype;
        logic [EVT_BITS-1:0]        ecode;
        logic signed [EVT_BITS-1:0] evalue;
        bit                         pinned;
        t_swipe                     want;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [EVT_BITS-1:0]           i_event_type = '0;
    logic [EVT_BITS-1:0]           i_event_code = '0;
    logic signed [EVT_BITS-1:0]    i_event_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [DIR_BITS-1:0]           o_direction;
    logic signed [TRAVEL_BITS-1:0] o_travel_x;
    logic signed [TRAVEL_BITS-1:0] o_travel_y;
    logic                          i_cfg_we = 1'b0;
    logic [EVT_BITS-1:0]           i_cfg_data = '0;

    bit     row_pinned = 1'b0;
    t_swipe row_want = '0;

    logic [EVT_BITS-1:0]        min_travel_cfg = MIN_TRAVEL_RESET;
    logic signed [EVT_BITS-1:0] stroke_first_x = '0;
    logic signed [EVT_BITS-1:0] stroke_first_y = '0;
    logic signed [EVT_BITS-1:0] stroke_last_x = '0;
    logic signed [EVT_BITS-1:0] stroke_last_y = '0;
    bit                         stroke_x_seen = 1'b0;
    bit                         stroke_y_seen = 1'b0;

    t_swipe    expected_swipes[$];
    t_stim_row directed_rows[$];
    int        error_count = 0;
    int        send_idle_pct = 30;
    int        recv_stall_pct = 69;
    bit        hold_go = 1'b0;
    logic      out_hold = 1'b0;

    touch_swipe_direction_classifier u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_event_type  (i_event_type),
        .i_event_code  (i_event_code),
        .i_event_value (i_event_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_direction   (o_direction),
        .o_travel_x    (o_travel_x),
        .o_travel_y    (o_travel_y),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Updates the stroke and returns 1 with the swipe when the event is a release.
    function automatic bit track_stroke(input logic [EVT_BITS-1:0] etype,
                                        input logic [EVT_BITS-1:0] ecode,
                                        input logic signed [EVT_BITS-1:0] evalue,
                                        output t_swipe res);
        int dx;
        int dy;
        int ax;
        int ay;
        int thr;
        res = '{DIR_NONE, '0, '0};
        track_stroke = 1'b0;
        if (etype == EVT_ABS && ecode == CODE_X) begin
            if (!stroke_x_seen) begin
                stroke_first_x = evalue;
                stroke_x_seen = 1'b1;
            end
            stroke_last_x = evalue;
        end else if (etype == EVT_ABS && ecode == CODE_Y) begin
            if (!stroke_y_seen) begin
                stroke_first_y = evalue;
                stroke_y_seen = 1'b1;
            end
            stroke_last_y = evalue;
        end else if (etype == EVT_KEY && ecode == CODE_TOUCH && evalue == 0) begin
            dx = stroke_x_seen ? int'(stroke_last_x) - int'(stroke_first_x) : 0;
            dy = stroke_y_seen ? int'(stroke_last_y) - int'(stroke_first_y) : 0;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            thr = int'(min_travel_cfg);
            if (dx > thr && ax > 2 * ay) begin
                res.dir = DIR_RIGHT;
            end else if (dx < -thr && ax > 2 * ay) begin
                res.dir = DIR_LEFT;
            end else if (dy > thr && ay > 2 * ax) begin
                res.dir = DIR_DOWN;
            end else if (dy < -thr && ay > 2 * ax) begin
                res.dir = DIR_UP;
            end
            res.tx = dx[TRAVEL_BITS-1:0];
            res.ty = dy[TRAVEL_BITS-1:0];
            stroke_first_x = '0;
            stroke_first_y = '0;
            stroke_last_x = '0;
            stroke_last_y = '0;
            stroke_x_seen = 1'b0;
            stroke_y_seen = 1'b0;
            track_stroke = 1'b1;
        end
    endfunction

    function automatic void add_row(input int etype, input int ecode, input int evalue,
                                    input bit pinned, input t_dir dir,
                                    input int tx, input int ty);
        t_stim_row r;
        r.etype = etype[EVT_BITS-1:0];
        r.ecode = ecode[EVT_BITS-1:0];
        r.evalue = evalue[EVT_BITS-1:0];
        r.pinned = pinned;
        r.want = '{dir, tx[TRAVEL_BITS-1:0], ty[TRAVEL_BITS-1:0]};
        directed_rows.push_back(r);
    endfunction

    // Called at a rising edge; returns at the edge where the transfer takes place.
    task automatic send_evt(input logic [EVT_BITS-1:0] etype,
                            input logic [EVT_BITS-1:0] ecode,
                            input logic signed [EVT_BITS-1:0] evalue,
                            input bit pinned, input t_swipe want);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_event_type <= etype;
        i_event_code <= ecode;
        i_event_value <= evalue;
        row_pinned <= pinned;
        row_want <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 5))
            0: send_evt(EVT_KEY, CODE_TOUCH, 16'($urandom_range(1, 65535)), 1'b0, '0);
            1: send_evt(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
            2: send_evt(EVT_ABS, CODE_TOUCH, 16'($urandom), 1'b0, '0);
            3: send_evt(EVT_KEY, CODE_X, 16'sd0, 1'b0, '0);
            4: send_evt(EVT_SYN, EVT_SYN, 16'sd0, 1'b0, '0);
            default: send_evt(EVT_ABS, 16'($urandom_range(2, 65535)), 16'($urandom), 1'b0, '0);
        endcase
    endtask

    task automatic send_stroke(inout int counted);
        int shape;
        int axis_events;
        int span_x;
        int span_y;
        int base_x;
        int base_y;
        bit use_x;
        shape = $urandom_range(0, 9);
        base_x = $urandom_range(0, 65535);
        base_y = $urandom_range(0, 65535);
        span_x = 16 << (3 * $urandom_range(0, 3));
        span_y = 16 << (3 * $urandom_range(0, 3));
        axis_events = (shape == 0) ? 0 : $urandom_range(1, 6);
        for (int k = 0; k < axis_events; k++) begin
            if ($urandom_range(99) < 15) begin
                send_noise();
            end
            use_x = (shape == 1) ? 1'b1 : (shape == 2) ? 1'b0 : 1'($urandom_range(0, 1));
            if (use_x) begin
                send_evt(EVT_ABS, CODE_X,
                         16'(base_x + $urandom_range(0, span_x) - span_x / 2), 1'b0, '0);
            end else begin
                send_evt(EVT_ABS, CODE_Y,
                         16'(base_y + $urandom_range(0, span_y) - span_y / 2), 1'b0, '0);
            end
            counted++;
        end
        if ($urandom_range(99) < 90) begin
            send_evt(EVT_KEY, CODE_TOUCH, 16'sd0, 1'b0, '0);
            counted++;
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_swipes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_min_travel(input logic [EVT_BITS-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        min_travel_cfg = value;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !out_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : long_hold
        wait (hold_go);
        @(posedge i_clk);
        out_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        out_hold <= 1'b0;
    end

    always @(posedge i_clk) begin : check_results
        t_swipe pred;
        t_swipe want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (track_stroke(i_event_type, i_event_code, i_event_value, pred)) begin
                    expected_swipes.push_back(row_pinned ? row_want : pred);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_swipes.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("Unexpected result: direction %0d travel_x %0d travel_y %0d",
                                 o_direction, o_travel_x, o_travel_y);
                    end
                end else begin
                    want = expected_swipes.pop_front();
                    if (o_direction !== want.dir || o_travel_x !== want.tx
                        || o_travel_y !== want.ty) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("Mismatch: direction %0d/%0d travel_x %0d/%0d %s %0d/%0d",
                                     want.dir, o_direction, want.tx, o_travel_x,
                                     "travel_y", want.ty, o_travel_y);
                        end
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int seg_items;
        add_row(EVT_KEY, CODE_TOUCH, 0, 1'b1, DIR_NONE, 0, 0);
        add_row(EVT_ABS, CODE_X, -32768, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_ABS, CODE_X, 32767, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_KEY, CODE_TOUCH, 0, 1'b1, DIR_RIGHT, 65535, 0);
        add_row(EVT_ABS, CODE_X, 32767, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_ABS, CODE_X, -32768, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_ABS, CODE_Y, 0, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_KEY, CODE_TOUCH, 0, 1'b1, DIR_LEFT, -65535, 0);
        add_row(EVT_ABS, CODE_Y, -32768, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_ABS, CODE_Y, 32767, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_KEY, CODE_TOUCH, 0, 1'b1, DIR_DOWN, 0, 65535);
        add_row(EVT_ABS, CODE_Y, 32767, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_ABS, CODE_Y, -32768, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_KEY, CODE_TOUCH, 0, 1'b1, DIR_UP, 0, -65535);
        add_row(EVT_ABS, CODE_X, 0, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_KEY, CODE_TOUCH, 1, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_ABS, CODE_X, 30, 1'b0, DIR_NONE, 0, 0);
        add_row(16'hFFFF, 16'hFFFF, -1, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_KEY, CODE_TOUCH, 0, 1'b1, DIR_NONE, 30, 0);
        add_row(EVT_ABS, CODE_X, 0, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_ABS, CODE_Y, 0, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_ABS, CODE_TOUCH, 0, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_KEY, CODE_X, 0, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_ABS, CODE_X, 100, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_ABS, CODE_Y, 50, 1'b0, DIR_NONE, 0, 0);
        add_row(EVT_KEY, CODE_TOUCH, 0, 1'b0, DIR_NONE, 0, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[i]) begin
            send_evt(directed_rows[i].etype, directed_rows[i].ecode, directed_rows[i].evalue,
                     directed_rows[i].pinned, directed_rows[i].want);
        end

        for (int seg = 0; seg < 6; seg++) begin
            settle();
            send_idle_pct <= (seg < 2) ? 30 : (seg < 4) ? 69 : 0;
            recv_stall_pct <= (seg < 2) ? 69 : (seg < 4) ? 30 : 0;
            case (seg)
                0: write_min_travel(16'd0);
                1: write_min_travel(16'hFFFF);
                2: write_min_travel(16'($urandom_range(1, 200)));
                3: write_min_travel(16'($urandom_range(0, 65535)));
                4: write_min_travel(MIN_TRAVEL_RESET);
                default: write_min_travel(16'($urandom_range(0, 400)));
            endcase
            if (seg == 4) begin
                hold_go = 1'b1;
            end
            seg_items = 0;
            while (seg_items < 90) send_stroke(seg_items);
        end
        settle();

        if (error_count == 0 && expected_swipes.size() == 0) begin
            $display("PASS touch_swipe_direction_classifier");
        end else begin
            $display("FAIL touch_swipe_direction_classifier");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAIL touch_swipe_direction_classifier");
        $finish;
    end

endmodule
